[rtl/drm_pkg.sv]
// Package for the dirty rectangle merge tracker.
// Sizes, item and entry structs, and sequencer states. No dependencies.
package drm_pkg;

	localparam int MAX_REGIONS = 8;
	localparam int COORD_BITS  = 16;
	localparam int DEPTH       = MAX_REGIONS + 1;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int AREA_W      = 2 * COORD_BITS;
	localparam int COST_W      = AREA_W + 2;

	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] left;
		logic signed [COORD_BITS-1:0] top;
		logic signed [COORD_BITS-1:0] right;
		logic signed [COORD_BITS-1:0] bottom;
	} box_t;

	typedef struct packed {
		box_t              box;
		logic [AREA_W-1:0] area;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic                         kind;
		logic signed [COORD_BITS-1:0] left;
		logic signed [COORD_BITS-1:0] top;
		logic signed [COORD_BITS-1:0] right;
		logic signed [COORD_BITS-1:0] bottom;
	} cmd_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] out_left;
		logic signed [COORD_BITS-1:0] out_top;
		logic signed [COORD_BITS-1:0] out_right;
		logic signed [COORD_BITS-1:0] out_bottom;
		logic                         valid_res;
		logic                         last;
	} res_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ADD_U,
		ST_ADD_M,
		ST_ADD_WR,
		ST_PS,
		ST_PR_RD,
		ST_PR_U,
		ST_PR_M,
		ST_PR_C,
		ST_PE,
		ST_MG_RD,
		ST_MG_U,
		ST_MG_M,
		ST_MG_WR,
		ST_SH_RD,
		ST_SH_WR,
		ST_DEC,
		ST_EM_RD,
		ST_EM_LD,
		ST_EM_EMPTY
	} state_t;

endpackage

[rtl/dirty_rect_merge_tracker.sv]
// Dirty rectangle merge tracker: list store, pair scan sequencer, output register.
// An add computes the new box's area in the shared union/multiply unit and appends it, then
// scans every pair in the list and merges the chosen pair, shifting later entries down; a
// flush repeats passes, then emits one item per entry, holding each while the output stalls.
// Each pair passes through the RAM read, the shared union/multiply unit and the compare.
// Reset clears the entry count, sequencer and output valid; the store is not cleared.
module dirty_rect_merge_tracker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  drm_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output drm_pkg::res_t res
);
	import drm_pkg::*;

	state_t                   state_q, state_d;
	cmd_t                     cmd_q;
	logic                     flush_q, forced_q, found_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [IDX_W-1:0]         i_q, j_q, bi_q, bj_q;
	logic signed [COST_W-1:0] best_q;
	logic                     res_valid_q;
	res_t                     res_q;

	box_t                     new_box;
	box_t                     ua, ub;
	logic [AREA_W-1:0]        ua_area, ub_area;
	box_t                     u_box;
	logic [AREA_W-1:0]        u_area;
	logic signed [COST_W-1:0] cost;
	entry_t                   rd0, rd1, wdata;
	logic                     we;
	logic [IDX_W-1:0]         waddr;
	logic                     accept, nonempty, out_free, last_pair, pick, em_last;
	logic                     res_load;
	logic [CNT_W-1:0]         i_x, j_x;

	assign new_box  = '{cmd_q.left, cmd_q.top, cmd_q.right, cmd_q.bottom};
	assign accept   = cmd_valid && !cmd_stall;
	assign nonempty = (cmd.left < cmd.right) && (cmd.top < cmd.bottom);
	assign out_free = !res_valid_q || !res_stall;
	assign res_load = out_free && ((state_q == ST_EM_LD) || (state_q == ST_EM_EMPTY));
	assign i_x      = CNT_W'(i_q);
	assign j_x      = CNT_W'(j_q);
	assign last_pair = (i_x + CNT_W'(2) == cnt_q) && (j_x + CNT_W'(1) == cnt_q);
	assign pick     = (forced_q && !found_q) || (cost < best_q);
	assign em_last  = (i_x + CNT_W'(1) == cnt_q);
	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	drm_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr0 (i_q),
		.raddr1 (j_q),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	drm_unit u_unit (
		.clk    (clk),
		.a      (ua),
		.b      (ub),
		.area_a (ua_area),
		.area_b (ub_area),
		.u_box  (u_box),
		.u_area (u_area),
		.cost   (cost)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd.kind == KIND_FLUSH) begin
						state_d = ST_PS;
					end else if (nonempty) begin
						state_d = ST_ADD_U;
					end
				end
			end
			ST_ADD_U:  state_d = ST_ADD_M;
			ST_ADD_M:  state_d = ST_ADD_WR;
			ST_ADD_WR: state_d = ST_PS;
			ST_PS: begin
				if (cnt_q > CNT_W'(1)) begin
					state_d = ST_PR_RD;
				end else if (flush_q) begin
					state_d = (cnt_q == '0) ? ST_EM_EMPTY : ST_EM_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PR_RD: state_d = ST_PR_U;
			ST_PR_U:  state_d = ST_PR_M;
			ST_PR_M:  state_d = ST_PR_C;
			ST_PR_C:  state_d = last_pair ? ST_PE : ST_PR_RD;
			ST_PE: begin
				if (found_q) begin
					state_d = ST_MG_RD;
				end else if (flush_q) begin
					state_d = ST_EM_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MG_RD: state_d = ST_MG_U;
			ST_MG_U:  state_d = ST_MG_M;
			ST_MG_M:  state_d = ST_MG_WR;
			ST_MG_WR: state_d = (j_x + CNT_W'(1) < cnt_q) ? ST_SH_RD : ST_DEC;
			ST_SH_RD: state_d = ST_SH_WR;
			ST_SH_WR: state_d = (j_x + CNT_W'(1) < cnt_q) ? ST_SH_RD : ST_DEC;
			ST_DEC:   state_d = flush_q ? ST_PS : ST_IDLE;
			ST_EM_RD: state_d = ST_EM_LD;
			ST_EM_LD: begin
				if (out_free) begin
					state_d = em_last ? ST_IDLE : ST_EM_RD;
				end
			end
			ST_EM_EMPTY: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ua      = rd0.box;
		ub      = rd1.box;
		ua_area = rd0.area;
		ub_area = rd1.area;
		we      = 1'b0;
		waddr   = i_q;
		wdata   = rd1;
		unique case (state_q)
			ST_ADD_U: begin
				ua = new_box;
				ub = new_box;
			end
			ST_ADD_WR: begin
				we    = 1'b1;
				waddr = cnt_q[IDX_W-1:0];
				wdata = '{new_box, u_area};
			end
			ST_MG_WR: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = '{u_box, u_area};
			end
			ST_SH_WR: begin
				we    = 1'b1;
				waddr = j_q - IDX_W'(1);
				wdata = rd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			flush_q     <= 1'b0;
			forced_q    <= 1'b0;
			found_q     <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			bi_q        <= '0;
			bj_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_load || (res_valid_q && res_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						flush_q  <= (cmd.kind == KIND_FLUSH);
						forced_q <= 1'b0;
					end
				end
				ST_ADD_WR: begin
					cnt_q    <= cnt_q + CNT_W'(1);
					forced_q <= (cnt_q + CNT_W'(1) == CNT_W'(DEPTH));
				end
				ST_PS: begin
					i_q     <= '0;
					j_q     <= IDX_W'(1);
					found_q <= 1'b0;
				end
				ST_PR_C: begin
					if (pick) begin
						found_q <= 1'b1;
						bi_q    <= i_q;
						bj_q    <= j_q;
					end
					if (j_x + CNT_W'(1) == cnt_q) begin
						i_q <= i_q + IDX_W'(1);
						j_q <= i_q + IDX_W'(2);
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				ST_PE: begin
					if (found_q) begin
						i_q <= bi_q;
						j_q <= bj_q;
					end else begin
						i_q <= '0;
					end
				end
				ST_MG_WR: j_q <= j_q + IDX_W'(1);
				ST_SH_WR: j_q <= j_q + IDX_W'(1);
				ST_DEC: begin
					cnt_q    <= cnt_q - CNT_W'(1);
					forced_q <= 1'b0;
				end
				ST_EM_LD: begin
					if (out_free) begin
						i_q <= i_q + IDX_W'(1);
						if (em_last) begin
							cnt_q <= '0;
						end
					end
				end
				ST_EM_EMPTY: begin
					if (out_free) begin
						cnt_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_PS) begin
			best_q <= '0;
		end else if (state_q == ST_PR_C && pick) begin
			best_q <= cost;
		end
		if (state_q == ST_EM_LD && out_free) begin
			res_q <= '{rd0.box.left, rd0.box.top, rd0.box.right, rd0.box.bottom,
				1'b1, em_last};
		end else if (state_q == ST_EM_EMPTY && out_free) begin
			res_q <= '{'0, '0, '0, '0, 1'b0, 1'b1};
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count beyond store depth");
	a_idle_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cnt_q <= CNT_W'(MAX_REGIONS)))
		else $error("list left full after add");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PR_RD) |-> (i_q < j_q) && (j_x < cnt_q))
		else $error("pair scan index out of order");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res)))
		else $error("stalled result item changed");
`endif

endmodule

[rtl/drm_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module drm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

[rtl/drm_unit.sv]
// Shared two-stage box unit: union box, union area and merge cost.
// Depends on drm_pkg.
module drm_unit (
	input  logic                              clk,
	input  drm_pkg::box_t                     a,
	input  drm_pkg::box_t                     b,
	input  logic [drm_pkg::AREA_W-1:0]        area_a,
	input  logic [drm_pkg::AREA_W-1:0]        area_b,
	output drm_pkg::box_t                     u_box,
	output logic [drm_pkg::AREA_W-1:0]        u_area,
	output logic signed [drm_pkg::COST_W-1:0] cost
);
	import drm_pkg::*;

	box_t                     u_c;
	logic signed [COORD_BITS:0] dw_c;
	logic signed [COORD_BITS:0] dh_c;
	box_t                     u_s1;
	logic [COORD_BITS-1:0]    w_s1;
	logic [COORD_BITS-1:0]    h_s1;
	logic [COST_W-1:0]        asum_s1;
	logic [AREA_W-1:0]        prod_c;

	always_comb begin
		u_c.left   = (a.left < b.left) ? a.left : b.left;
		u_c.top    = (a.top < b.top) ? a.top : b.top;
		u_c.right  = (a.right > b.right) ? a.right : b.right;
		u_c.bottom = (a.bottom > b.bottom) ? a.bottom : b.bottom;
		dw_c = {u_c.right[COORD_BITS-1], u_c.right} - {u_c.left[COORD_BITS-1], u_c.left};
		dh_c = {u_c.bottom[COORD_BITS-1], u_c.bottom} - {u_c.top[COORD_BITS-1], u_c.top};
	end

	assign prod_c = w_s1 * h_s1;

	always_ff @(posedge clk) begin
		u_s1    <= u_c;
		w_s1    <= dw_c[COORD_BITS-1:0];
		h_s1    <= dh_c[COORD_BITS-1:0];
		asum_s1 <= {2'b00, area_a} + {2'b00, area_b};
		u_box   <= u_s1;
		u_area  <= prod_c;
		cost    <= $signed({2'b00, prod_c}) - $signed(asum_s1);
	end

endmodule
